// ===== rtl/core/nds_pkg.sv =====
// Shared types, phase codes and Q3.29 ROM tables for the normal deviate sampler.
// Depends on nothing; used by nds_front, nds_back and normal_deviate_sampler.
`default_nettype none
package nds_pkg;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_C_WIDTH   = 3'd1,
      PH_C_TEST    = 3'd2,
      PH_T_STAR    = 3'd3,
      PH_C_RESTART = 3'd4,
      PH_C_STAR    = 3'd5,
      PH_T_TEST    = 3'd6,
      PH_T_WIDTH   = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      EX_WAIT   = 3'd0,
      EX_LOOP   = 3'd1,
      EX_SCALE  = 3'd2,
      EX_BOUND  = 3'd3,
      EX_DECIDE = 3'd4,
      EX_OUT    = 3'd5
   } ex_type;

   // head of the uniform queue as seen by the back end
   typedef struct packed {
      logic        avail;
      logic [31:0] uniform;
   } fq_type;

   // convert a value in units of 1e-10 to Q3.29, rounded
   function automatic logic [31:0] q29(input logic [63:0] n);
      logic [63:0] r;
      r = (n * 64'd536870912 + 64'd5000000000) / 64'd10000000000;
      return r[31:0];
   endfunction

   localparam logic [31:0] TAB_A [32] = '{
      q29(64'd0), q29(64'd391760900), q29(64'd784124100), q29(64'd1177699000),
      q29(64'd1573107000), q29(64'd1970991000), q29(64'd2372021000),
      q29(64'd2776904000), q29(64'd3186394000), q29(64'd3601299000),
      q29(64'd4022501000), q29(64'd4450965000), q29(64'd4887764000),
      q29(64'd5334097000), q29(64'd5791322000), q29(64'd6260990000),
      q29(64'd6744898000), q29(64'd7245144000), q29(64'd7764218000),
      q29(64'd8305109000), q29(64'd8871466000), q29(64'd9467818000),
      q29(64'd10099900000), q29(64'd10775160000), q29(64'd11503490000),
      q29(64'd12298590000), q29(64'd13180110000), q29(64'd14177970000),
      q29(64'd15341210000), q29(64'd16759400000), q29(64'd18627320000),
      q29(64'd21538750000)
   };

   localparam logic [31:0] TAB_D [31] = '{
      q29(64'd0), q29(64'd0), q29(64'd0), q29(64'd0), q29(64'd0),
      q29(64'd2636843000), q29(64'd2425085000), q29(64'd2255674000),
      q29(64'd2116342000), q29(64'd1999243000), q29(64'd1899108000),
      q29(64'd1812252000), q29(64'd1736014000), q29(64'd1668419000),
      q29(64'd1607967000), q29(64'd1553497000), q29(64'd1504094000),
      q29(64'd1459026000), q29(64'd1417700000), q29(64'd1379632000),
      q29(64'd1344418000), q29(64'd1311722000), q29(64'd1281260000),
      q29(64'd1252791000), q29(64'd1226109000), q29(64'd1201036000),
      q29(64'd1177417000), q29(64'd1155119000), q29(64'd1134023000),
      q29(64'd1114027000), q29(64'd1095039000)
   };

   localparam logic [31:0] TAB_T [31] = '{
      q29(64'd7673828), q29(64'd23068700), q29(64'd38606180), q29(64'd54384540),
      q29(64'd70506990), q29(64'd87083960), q29(64'd104235700),
      q29(64'd122095300), q29(64'd140812500), q29(64'd160557900),
      q29(64'd181529000), q29(64'd203957300), q29(64'd228117700),
      q29(64'd254340700), q29(64'd283029600), q29(64'd314682200),
      q29(64'd349923300), q29(64'd389548300), q29(64'd434587800),
      q29(64'd486403500), q29(64'd546833400), q29(64'd618422200),
      q29(64'd704798300), q29(64'd811319500), q29(64'd946244400),
      q29(64'd1123001000), q29(64'd1364980000), q29(64'd1716886000),
      q29(64'd2276241000), q29(64'd3304980000), q29(64'd5847031000)
   };

   localparam logic [31:0] TAB_H [31] = '{
      q29(64'd392061700), q29(64'd393270500), q29(64'd395099900),
      q29(64'd397570300), q29(64'd400709300), q29(64'd404553300),
      q29(64'd409148100), q29(64'd414550700), q29(64'd420831100),
      q29(64'd428074800), q29(64'd436386300), q29(64'd445893200),
      q29(64'd456752300), q29(64'd469157100), q29(64'd483348700),
      q29(64'd499629800), q29(64'd518385900), q29(64'd540113800),
      q29(64'd565465600), q29(64'd595313000), q29(64'd630848900),
      q29(64'd673750300), q29(64'd726454400), q29(64'd792647100),
      q29(64'd878192200), q29(64'd993039800), q29(64'd1155599000),
      q29(64'd1404344000), q29(64'd1836142000), q29(64'd2790016000),
      q29(64'd7010474000)
   };

endpackage
`default_nettype wire

// ===== rtl/core/nds_front.sv =====
// Front end: accepts uniforms, normalizes them to 0.32 and queues two of them.
// Depends on nds_pkg for the queue-head struct.
`default_nettype none
module nds_front #(
   parameter int UNIFORM_BITS = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_push,
   output logic                         req_full,
   input  wire logic [UNIFORM_BITS-1:0] req_uniform,
   output nds_pkg::fq_type              fq,
   input  wire logic                    take
);

   logic [31:0] norm;
   logic [31:0] mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        do_push, do_pop;

   generate
      if (UNIFORM_BITS >= 32) begin : g_trunc
         assign norm = req_uniform[UNIFORM_BITS-1 -: 32];
      end else begin : g_fill
         assign norm = {req_uniform, {(32-UNIFORM_BITS){1'b0}}};
      end
   endgenerate

   assign req_full   = (cnt_ff == 2'd2);
   assign do_push    = req_push && !req_full;
   assign do_pop     = take && (cnt_ff != 2'd0);
   assign fq.avail   = (cnt_ff != 2'd0);
   assign fq.uniform = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= norm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/nds_back.sv =====
// Back end: rejection sequencer with a shared 32x32 multiplier and a result register.
// Depends on nds_pkg for phase codes, sequencer states and ROM tables.
`default_nettype none
module nds_back #(
   parameter int OUT_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire nds_pkg::fq_type       fq,
   output logic                       take,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic signed [OUT_BITS-1:0] rsp_deviate,
   output logic [4:0]                 rsp_interval_index
);

   localparam int SHR  = (OUT_BITS <= 35) ? 35 - OUT_BITS : 0;
   localparam int SHL  = (OUT_BITS > 35) ? OUT_BITS - 35 : 0;
   localparam logic [63:0] HALF = (SHR > 0) ? (64'd1 << (SHR - 1)) : 64'd0;

   nds_pkg::ex_type    ex_ff, ex_in;
   nds_pkg::phase_type phase_ff, phase_in;
   logic        negate_ff, negate_in;
   logic [4:0]  interval_ff, interval_in;
   logic [31:0] base_ff, base_in;
   logic [31:0] fstar_ff, fstar_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] bound_ff, bound_in;
   logic [31:0] mul_a_ff, mul_a_in;
   logic [31:0] mul_b_ff, mul_b_in;
   logic [31:0] sc_ff, sc_in;
   logic        to_emit_ff, to_emit_in;
   logic        tail_ff, tail_in;
   logic [31:0] f_ff, f_in;
   logic [5:0]  k_ff, k_in;
   logic        out_valid_ff, out_valid_in;
   logic [OUT_BITS-1:0] out_dev_ff, out_dev_in;
   logic [4:0]  out_idx_ff, out_idx_in;

   function automatic logic [31:0] TAB_T_lookup(input logic [4:0] ix);
      return (ix > 5'd30) ? nds_pkg::TAB_T[30] : nds_pkg::TAB_T[ix];
   endfunction

   function automatic logic [31:0] TAB_H_lookup(input logic [4:0] ix);
      return (ix > 5'd30) ? nds_pkg::TAB_H[30] : nds_pkg::TAB_H[ix];
   endfunction

   function automatic logic [31:0] TAB_D_lookup(input logic [4:0] ix);
      return (ix > 5'd30) ? nds_pkg::TAB_D[30] : nds_pkg::TAB_D[ix];
   endfunction

   assign rsp_empty          = !out_valid_ff;
   assign rsp_deviate        = out_dev_ff;
   assign rsp_interval_index = out_idx_ff;

   always_comb begin
      logic [4:0]  lo;
      logic [31:0] u;
      logic [34:0] tq_lo;
      logic [32:0] v;
      logic [37:0] vs;
      logic [37:0] st38;
      logic [5:0]  iw;
      logic [4:0]  i0;
      logic [4:0]  i0m;
      logic [31:0] st;
      logic [34:0] tq0;
      logic [31:0] span;
      logic [63:0] prod;
      logic [33:0] bsum;
      logic [65:0] bprod;
      logic [38:0] pb;
      logic [31:0] mag;
      logic [63:0] rnd;
      logic        slot_free;

      ex_in        = ex_ff;
      phase_in     = phase_ff;
      negate_in    = negate_ff;
      interval_in  = interval_ff;
      base_in      = base_ff;
      fstar_in     = fstar_ff;
      offset_in    = offset_ff;
      bound_in     = bound_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      sc_in        = sc_ff;
      to_emit_in   = to_emit_ff;
      tail_in      = tail_ff;
      f_in         = f_ff;
      k_in         = k_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_dev_in   = out_dev_ff;
      out_idx_in   = out_idx_ff;
      take         = 1'b0;
      slot_free    = !out_valid_ff || rsp_pop;

      lo = interval_ff - 5'd1;
      if (lo == 5'd31) begin
         lo = 5'd30;
      end
      u     = fq.uniform;
      tq_lo = {TAB_T_lookup(lo), 3'b000};

      // first uniform of a draw: sign, interval and leftover fraction
      v         = {u, 1'b0};
      if (u > 32'h8000_0000) begin
         v = v - 33'h1_0000_0000;
      end
      iw   = v[32:27];
      i0   = (iw > 6'd31) ? 5'd31 : iw[4:0];
      i0m  = i0 - 5'd1;
      vs   = {v, 5'b00000};
      st38 = vs - {1'b0, i0, 32'h0};
      st   = (st38 > 38'h00_FFFF_FFFF) ? 32'hFFFF_FFFF : st38[31:0];
      tq0  = {TAB_T_lookup(i0m), 3'b000};

      span = (interval_ff > lo) ? (nds_pkg::TAB_A[interval_ff] - nds_pkg::TAB_A[lo]) : 32'd0;

      prod  = mul_a_ff * mul_b_ff;
      bsum  = {2'b00, sc_ff} + {1'b0, base_ff, 1'b0};
      bprod = bsum * {34'd0, sc_ff};
      pb    = bprod[65:27];

      mag = base_ff + sc_ff;
      rnd = ((({32'd0, mag}) + HALF) >> SHR) << SHL;
      if (negate_ff) begin
         rnd = 64'd0 - rnd;
      end

      case (ex_ff)
         nds_pkg::EX_WAIT: begin
            if (fq.avail) begin
               take = 1'b1;
               case (phase_ff)
                  nds_pkg::PH_C_WIDTH: begin
                     mul_a_in   = u;
                     mul_b_in   = span;
                     to_emit_in = 1'b0;
                     tail_in    = 1'b0;
                     ex_in      = nds_pkg::EX_SCALE;
                  end
                  nds_pkg::PH_C_TEST, nds_pkg::PH_T_TEST: begin
                     if (fstar_ff < u) begin
                        phase_in = (phase_ff == nds_pkg::PH_C_TEST) ?
                                   nds_pkg::PH_C_RESTART : nds_pkg::PH_T_WIDTH;
                     end else begin
                        bound_in = u;
                        phase_in = (phase_ff == nds_pkg::PH_C_TEST) ?
                                   nds_pkg::PH_C_STAR : nds_pkg::PH_T_STAR;
                     end
                  end
                  nds_pkg::PH_C_RESTART: begin
                     fstar_in = u;
                     if ({3'b000, u} <= tq_lo) begin
                        phase_in = nds_pkg::PH_C_WIDTH;
                     end else begin
                        mul_a_in   = u - tq_lo[31:0];
                        mul_b_in   = TAB_H_lookup(lo);
                        to_emit_in = 1'b1;
                        tail_in    = 1'b0;
                        ex_in      = nds_pkg::EX_SCALE;
                     end
                  end
                  nds_pkg::PH_C_STAR, nds_pkg::PH_T_STAR: begin
                     fstar_in = u;
                     if (u > bound_ff) begin
                        sc_in   = offset_ff;
                        tail_in = (phase_ff == nds_pkg::PH_T_STAR);
                        ex_in   = nds_pkg::EX_OUT;
                     end else begin
                        phase_in = (phase_ff == nds_pkg::PH_C_STAR) ?
                                   nds_pkg::PH_C_TEST : nds_pkg::PH_T_TEST;
                     end
                  end
                  nds_pkg::PH_T_WIDTH: begin
                     mul_a_in   = u;
                     mul_b_in   = TAB_D_lookup(lo);
                     to_emit_in = 1'b0;
                     tail_in    = 1'b1;
                     ex_in      = nds_pkg::EX_SCALE;
                  end
                  default: begin
                     negate_in = (u > 32'h8000_0000);
                     if (i0 != 5'd0) begin
                        interval_in = i0;
                        base_in     = nds_pkg::TAB_A[i0m];
                        fstar_in    = st;
                        if ({3'b000, st} > tq0) begin
                           mul_a_in   = st - tq0[31:0];
                           mul_b_in   = TAB_H_lookup(i0m);
                           to_emit_in = 1'b1;
                           tail_in    = 1'b0;
                           ex_in      = nds_pkg::EX_SCALE;
                        end else begin
                           phase_in = nds_pkg::PH_C_WIDTH;
                        end
                     end else begin
                        f_in        = vs[31:0];
                        base_in     = nds_pkg::TAB_A[31];
                        interval_in = 5'd6;
                        k_in        = 6'd0;
                        ex_in       = nds_pkg::EX_LOOP;
                     end
                  end
               endcase
            end
         end
         nds_pkg::EX_LOOP: begin
            // one doubling per cycle until the leading one appears
            if (k_ff < 6'd32 && !f_ff[31]) begin
               base_in = base_ff + TAB_D_lookup(interval_ff - 5'd1);
               if (interval_ff < 5'd31) begin
                  interval_in = interval_ff + 5'd1;
               end
               k_in = k_ff + 6'd1;
               f_in = {f_ff[30:0], 1'b0};
            end else begin
               mul_a_in   = {f_ff[30:0], 1'b0};
               mul_b_in   = TAB_D_lookup(interval_ff - 5'd1);
               to_emit_in = 1'b0;
               tail_in    = 1'b1;
               ex_in      = nds_pkg::EX_SCALE;
            end
         end
         nds_pkg::EX_SCALE: begin
            sc_in = prod[63:32];
            ex_in = to_emit_ff ? nds_pkg::EX_OUT : nds_pkg::EX_BOUND;
         end
         nds_pkg::EX_BOUND: begin
            offset_in = sc_ff;
            bound_in  = (pb[38:32] != 7'd0) ? 32'hFFFF_FFFF : pb[31:0];
            if (tail_ff) begin
               phase_in = nds_pkg::PH_T_STAR;
               ex_in    = nds_pkg::EX_WAIT;
            end else begin
               ex_in = nds_pkg::EX_DECIDE;
            end
         end
         nds_pkg::EX_DECIDE: begin
            if (fstar_ff > bound_ff) begin
               sc_in = offset_ff;
               ex_in = nds_pkg::EX_OUT;
            end else begin
               phase_in = nds_pkg::PH_C_TEST;
               ex_in    = nds_pkg::EX_WAIT;
            end
         end
         nds_pkg::EX_OUT: begin
            // hold until the result register is free
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_dev_in   = rnd[OUT_BITS-1:0];
               out_idx_in   = tail_ff ? 5'd0 : interval_ff;
               phase_in     = nds_pkg::PH_IDLE;
               ex_in        = nds_pkg::EX_WAIT;
            end
         end
         default: begin
            ex_in = nds_pkg::EX_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      sc_ff      <= sc_in;
      to_emit_ff <= to_emit_in;
      tail_ff    <= tail_in;
      f_ff       <= f_in;
      k_ff       <= k_in;
      out_dev_ff <= out_dev_in;
      out_idx_ff <= out_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_ff        <= nds_pkg::EX_WAIT;
         phase_ff     <= nds_pkg::PH_IDLE;
         negate_ff    <= 1'b0;
         interval_ff  <= 5'd0;
         base_ff      <= 32'd0;
         fstar_ff     <= 32'd0;
         offset_ff    <= 32'd0;
         bound_ff     <= 32'd0;
         out_valid_ff <= 1'b0;
      end else begin
         ex_ff        <= ex_in;
         phase_ff     <= phase_in;
         negate_ff    <= negate_in;
         interval_ff  <= interval_in;
         base_ff      <= base_in;
         fstar_ff     <= fstar_in;
         offset_ff    <= offset_in;
         bound_ff     <= bound_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/normal_deviate_sampler.sv =====
// Flow: a pushed uniform is registered in the two-entry input queue; the back end takes
// it only while waiting. Compare-only steps return to wait; a step that uses the shared
// multiplier goes to scale, then to output or bound; bound leads to decide or back to
// wait (tail), decide to output or wait, and output holds until the result slot is free.
// A tail first uniform runs the doubling loop before its scale and bound steps.
// Reset: synchronous, clears the queue, sequencer, draw state and result valid flag.
`default_nettype none
module normal_deviate_sampler #(
   parameter int UNIFORM_BITS = 32,
   parameter int OUT_BITS     = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_push,
   output logic                         req_full,
   input  wire logic [UNIFORM_BITS-1:0] req_uniform,
   output logic                         rsp_empty,
   input  wire logic                    rsp_pop,
   output logic signed [OUT_BITS-1:0]   rsp_deviate,
   output logic [4:0]                   rsp_interval_index
);

   nds_pkg::fq_type fq;
   logic            take;

   nds_front #(
      .UNIFORM_BITS (UNIFORM_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_uniform (req_uniform),
      .fq          (fq),
      .take        (take)
   );

   nds_back #(
      .OUT_BITS (OUT_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .fq                 (fq),
      .take               (take),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_deviate        (rsp_deviate),
      .rsp_interval_index (rsp_interval_index)
   );

endmodule
`default_nettype wire
